// ===== sv/pixel_tint_compose_blend_defines.svh =====
// Assertion macros for the pixel blend block
`ifndef PIXEL_TINT_COMPOSE_BLEND_DEFINES_SVH
`define PIXEL_TINT_COMPOSE_BLEND_DEFINES_SVH

// check while out of reset
`define PTCB_ASSERT_RUN(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check at every edge, reset included
`define PTCB_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/ptcb_pkg.sv =====
package ptcb_pkg;

   localparam logic MODE_TINT    = 1'b0;
   localparam logic MODE_COMPOSE = 1'b1;

   localparam logic [1:0] FMT_32  = 2'd0;
   localparam logic [1:0] FMT_24  = 2'd1;
   localparam logic [1:0] FMT_565 = 2'd2;
   localparam logic [1:0] FMT_555 = 2'd3;

   localparam logic [1:0] REG_MODE       = 2'd0;
   localparam logic [1:0] REG_FORMAT     = 2'd1;
   localparam logic [1:0] REG_TINT_COLOR = 2'd2;
   localparam logic [1:0] REG_TINT_ALPHA = 2'd3;

   localparam logic [15:0] MASK565_R = 16'hf800;
   localparam logic [15:0] MASK565_G = 16'h07e0;
   localparam logic [15:0] MASK555_R = 16'h7c00;
   localparam logic [15:0] MASK555_G = 16'h03e0;
   localparam logic [15:0] MASK_B    = 16'h001f;

   localparam logic [7:0] FULL_WEIGHT = 8'd255;

   localparam int LANES  = 3;
   localparam int LANE_W = 16;
   localparam int PROD_W = 24;

   typedef logic [LANES-1:0][LANE_W-1:0] lane_type;
   typedef logic [LANES-1:0][PROD_W-1:0] prod_type;

   typedef struct packed {
      logic        mode;
      logic [1:0]  format;
      logic [23:0] tint_color;
      logic [7:0]  tint_alpha;
   } cfg_type;

   typedef struct packed {
      logic       last;
      logic       packed_fmt;
      logic       is565;
      logic       split_sum;
      logic [7:0] top;
   } ctl_type;

   // lane 0 blue, lane 1 green, lane 2 red
   function automatic logic [15:0] field_mask(logic is565, logic [1:0] lane);
      logic [15:0] m;
      case (lane)
         2'd0:    m = MASK_B;
         2'd1:    m = is565 ? MASK565_G : MASK555_G;
         2'd2:    m = is565 ? MASK565_R : MASK555_R;
         default: m = 16'h0000;
      endcase
      return m;
   endfunction

endpackage

// ===== sv/pixel_tint_compose_blend.sv =====
// Pixel blend unit: tints a pixel toward a fixed colour, or composes a
// foreground pixel over a background pixel under a per-pixel mask weight.
// Formats: 32bpp (top byte kept), 24bpp, 16bpp 565 and 15bpp 555.
// Input channel req_*: one beat per pixel, tdata = fore, back, mask;
// tlast marks the last pixel of an image and comes back on rsp_tlast.
// Result channel rsp_*: one beat per input beat, in order.
// Registers (csr_*): 0 mode, 1 format, 2 tint colour, 3 tint alpha;
// write them only while no pixel is in flight.
// An accepted req beat reaches rsp_tvalid through the registered operand
// stage, the multiplier stage and the sum/pack stage, in that order.
// Throughput: one pixel per clock while rsp_tready stays high.
// On an rsp stall each stage holds its beat and fills its bubbles; once
// all three stages are full, req_tready drops until the receiver takes one.
// Reset empties the pipeline and clears the configuration registers to zero.
module pixel_tint_compose_blend (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // fore_pixel[31:0], back_pixel[63:32], mask_alpha[71:64]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_pixel[31:0]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   ptcb_pkg::cfg_type  cfg_ff, cfg_in;
   logic               csr_write;

   logic               s1_valid, s1_ready, s2_valid, s2_ready;
   ptcb_pkg::lane_type s1_x, s1_y;
   logic [7:0]         s1_wx, s1_wy;
   ptcb_pkg::ctl_type  s1_ctl, s2_ctl;
   ptcb_pkg::prod_type s2_px, s2_py;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            ptcb_pkg::REG_MODE:       cfg_in.mode       = csr_pwdata[0];
            ptcb_pkg::REG_FORMAT:     cfg_in.format     = csr_pwdata[1:0];
            ptcb_pkg::REG_TINT_COLOR: cfg_in.tint_color = csr_pwdata[23:0];
            ptcb_pkg::REG_TINT_ALPHA: cfg_in.tint_alpha = csr_pwdata[7:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         ptcb_pkg::REG_MODE:       csr_prdata = {31'd0, cfg_ff.mode};
         ptcb_pkg::REG_FORMAT:     csr_prdata = {30'd0, cfg_ff.format};
         ptcb_pkg::REG_TINT_COLOR: csr_prdata = {8'd0, cfg_ff.tint_color};
         ptcb_pkg::REG_TINT_ALPHA: csr_prdata = {24'd0, cfg_ff.tint_alpha};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ptcb_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .fore_pixel (req_tdata[31:0]),
      .back_pixel (req_tdata[63:32]),
      .mask_alpha (req_tdata[71:64]),
      .last_pixel (req_tlast),
      .out_valid  (s1_valid),
      .out_ready  (s1_ready),
      .x_out      (s1_x),
      .y_out      (s1_y),
      .wx_out     (s1_wx),
      .wy_out     (s1_wy),
      .ctl_out    (s1_ctl)
   );

   ptcb_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid),
      .in_ready   (s1_ready),
      .x_in_lanes (s1_x),
      .y_in_lanes (s1_y),
      .wx         (s1_wx),
      .wy         (s1_wy),
      .ctl_in     (s1_ctl),
      .out_valid  (s2_valid),
      .out_ready  (s2_ready),
      .px_out     (s2_px),
      .py_out     (s2_py),
      .ctl_out    (s2_ctl)
   );

   ptcb_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .px        (s2_px),
      .py        (s2_py),
      .ctl       (s2_ctl),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pixel (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

// ===== sv/ptcb_prep.sv =====
module ptcb_prep (
   input  logic                 clock,
   input  logic                 reset,
   input  ptcb_pkg::cfg_type    cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [31:0]          fore_pixel,
   input  logic [31:0]          back_pixel,
   input  logic [7:0]           mask_alpha,
   input  logic                 last_pixel,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ptcb_pkg::lane_type   x_out,
   output ptcb_pkg::lane_type   y_out,
   output logic [7:0]           wx_out,
   output logic [7:0]           wy_out,
   output ptcb_pkg::ctl_type    ctl_out
);

   logic               valid_ff, valid_in;
   ptcb_pkg::lane_type x_ff, x_in, y_ff, y_in;
   logic [7:0]         wx_ff, wx_in, wy_ff, wy_in;
   ptcb_pkg::ctl_type  ctl_ff, ctl_in;
   logic               tint, packed_fmt, is565;
   logic [31:0]        other;

   always_comb begin
      tint       = (cfg.mode == ptcb_pkg::MODE_TINT);
      packed_fmt = (cfg.format == ptcb_pkg::FMT_565) || (cfg.format == ptcb_pkg::FMT_555);
      is565      = (cfg.format == ptcb_pkg::FMT_565);
      other      = tint ? {8'h00, cfg.tint_color} : back_pixel;
      wx_in      = tint ? (ptcb_pkg::FULL_WEIGHT - cfg.tint_alpha) : mask_alpha;
      wy_in      = tint ? cfg.tint_alpha : (ptcb_pkg::FULL_WEIGHT - mask_alpha);
      for (int k = 0; k < ptcb_pkg::LANES; k++) begin
         if (packed_fmt) begin
            x_in[k] = fore_pixel[15:0] & ptcb_pkg::field_mask(is565, 2'(k));
            y_in[k] = other[15:0] & ptcb_pkg::field_mask(is565, 2'(k));
         end else begin
            x_in[k] = {8'h00, fore_pixel[8*k +: 8]};
            y_in[k] = {8'h00, other[8*k +: 8]};
         end
      end
      ctl_in.last       = last_pixel;
      ctl_in.packed_fmt = packed_fmt;
      ctl_in.is565      = is565;
      ctl_in.split_sum  = tint && !packed_fmt;
      ctl_in.top        = (cfg.format == ptcb_pkg::FMT_32) ? fore_pixel[31:24] : 8'h00;
      valid_in          = in_ready ? in_valid : valid_ff;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         wx_ff  <= wx_in;
         wy_ff  <= wy_in;
         ctl_ff <= ctl_in;
      end
   end

   assign out_valid = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign wx_out    = wx_ff;
   assign wy_out    = wy_ff;
   assign ctl_out   = ctl_ff;

endmodule

// ===== sv/ptcb_mul.sv =====
module ptcb_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  ptcb_pkg::lane_type   x_in_lanes,
   input  ptcb_pkg::lane_type   y_in_lanes,
   input  logic [7:0]           wx,
   input  logic [7:0]           wy,
   input  ptcb_pkg::ctl_type    ctl_in,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ptcb_pkg::prod_type   px_out,
   output ptcb_pkg::prod_type   py_out,
   output ptcb_pkg::ctl_type    ctl_out
);

   logic               valid_ff, valid_in;
   ptcb_pkg::prod_type px_ff, px_in, py_ff, py_in;
   ptcb_pkg::ctl_type  ctl_ff;

   always_comb begin
      for (int k = 0; k < ptcb_pkg::LANES; k++) begin
         px_in[k] = x_in_lanes[k] * wx;
         py_in[k] = y_in_lanes[k] * wy;
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         px_ff  <= px_in;
         py_ff  <= py_in;
         ctl_ff <= ctl_in;
      end
   end

   assign out_valid = valid_ff;
   assign px_out    = px_ff;
   assign py_out    = py_ff;
   assign ctl_out   = ctl_ff;

endmodule

// ===== sv/ptcb_pack.sv =====
module ptcb_pack (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  ptcb_pkg::prod_type   px,
   input  ptcb_pkg::prod_type   py,
   input  ptcb_pkg::ctl_type    ctl,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [31:0]          out_pixel,
   output logic                 out_last
);

   logic        valid_ff, valid_in;
   logic [31:0] pixel_ff, pixel_in;
   logic        last_ff;
   logic [24:0] sum;
   logic [15:0] packed_acc;
   logic [23:0] bytes;

   always_comb begin
      packed_acc = 16'h0000;
      bytes      = 24'h000000;
      sum        = 25'd0;
      for (int k = 0; k < ptcb_pkg::LANES; k++) begin
         sum = {1'b0, px[k]} + {1'b0, py[k]};
         packed_acc = packed_acc
                    | (sum[23:8] & ptcb_pkg::field_mask(ctl.is565, 2'(k)));
         if (ctl.split_sum) begin
            bytes[8*k +: 8] = px[k][15:8] + py[k][15:8];
         end else begin
            bytes[8*k +: 8] = sum[15:8];
         end
      end
      pixel_in = ctl.packed_fmt ? {16'h0000, packed_acc} : {ctl.top, bytes};
      valid_in = in_ready ? in_valid : valid_ff;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pixel_ff <= pixel_in;
         last_ff  <= ctl.last;
      end
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;
   assign out_last  = last_ff;

endmodule

// ===== sv/ptcb_checker.sv =====
`include "pixel_tint_compose_blend_defines.svh"

module ptcb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   `PTCB_ASSERT_ALWAYS(a_reset_empties, reset |=> (!rsp_tvalid && req_tready), "pipeline not empty after reset")
   `PTCB_ASSERT_RUN(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)), "result beat changed while stalled")
   `PTCB_ASSERT_RUN(a_ready_flows, rsp_tready |-> req_tready, "input stalled while output drains")
   `PTCB_ASSERT_RUN(a_latency, (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid, "accepted beat missing at output after three cycles")

endmodule

bind pixel_tint_compose_blend ptcb_checker u_ptcb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== bench/pixel_blend_checker.sv =====
`timescale 1ns / 100ps

module pixel_blend_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,   // fore_pixel[31:0], back_pixel[63:32], mask_alpha[71:64]
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // out_pixel[31:0]
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          pending_count
);

   typedef struct {
      logic [31:0] pixel;
      logic        last;
   } blended_beat_type;

   ptcb_pkg::cfg_type blend_cfg;
   blended_beat_type  pending_pixels[$];

   function automatic logic [7:0] mix_byte(logic [7:0] x, logic [7:0] wx, logic [7:0] y,
                                           logic [7:0] wy, logic split);
      logic [16:0] acc;
      if (split)
         acc = ((x * wx) >> 8) + ((y * wy) >> 8);
      else
         acc = (x * wx + y * wy) >> 8;
      return acc[7:0];
   endfunction

   function automatic logic [15:0] mix_field(logic [15:0] x, logic [7:0] wx, logic [15:0] y,
                                             logic [7:0] wy, logic [15:0] fm);
      logic [31:0] acc;
      acc = (x & fm) * wx + (y & fm) * wy;
      return acc[23:8] & fm;
   endfunction

   function automatic logic [31:0] blended_pixel(ptcb_pkg::cfg_type c, logic [31:0] f,
                                                 logic [31:0] b, logic [7:0] m);
      logic        is_tint;
      logic [7:0]  wf;
      logic [7:0]  wb;
      logic [31:0] other;
      logic [31:0] res;
      logic [15:0] mr;
      logic [15:0] mg;
      is_tint = (c.mode == ptcb_pkg::MODE_TINT);
      wf      = is_tint ? ptcb_pkg::FULL_WEIGHT - c.tint_alpha : m;
      wb      = is_tint ? c.tint_alpha : ptcb_pkg::FULL_WEIGHT - m;
      other   = is_tint ? {8'h00, c.tint_color} : b;
      res     = '0;
      if (c.format == ptcb_pkg::FMT_32 || c.format == ptcb_pkg::FMT_24) begin
         for (int k = 0; k < 3; k++)
            res[8*k +: 8] = mix_byte(f[8*k +: 8], wf, other[8*k +: 8], wb, is_tint);
         if (c.format == ptcb_pkg::FMT_32)
            res[31:24] = f[31:24];
      end else begin
         mr = (c.format == ptcb_pkg::FMT_565) ? ptcb_pkg::MASK565_R : ptcb_pkg::MASK555_R;
         mg = (c.format == ptcb_pkg::FMT_565) ? ptcb_pkg::MASK565_G : ptcb_pkg::MASK555_G;
         res[15:0] = mix_field(f[15:0], wf, other[15:0], wb, mr) |
                     mix_field(f[15:0], wf, other[15:0], wb, mg) |
                     mix_field(f[15:0], wf, other[15:0], wb, ptcb_pkg::MASK_B);
      end
      return res;
   endfunction

   always @(posedge clock) begin
      blended_beat_type want;
      if (reset) begin
         blend_cfg <= '0;
         pending_pixels.delete();
         mismatch_count <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               $error("rsp beat with no pixel pending: out_pixel %h out_last %b",
                      rsp_tdata, rsp_tlast);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_tdata !== want.pixel || rsp_tlast !== want.last) begin
                  if (rsp_tdata !== want.pixel)
                     $error("out_pixel expected %h actual %h", want.pixel, rsp_tdata);
                  if (rsp_tlast !== want.last)
                     $error("out_last expected %b actual %b", want.last, rsp_tlast);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want.pixel = blended_pixel(blend_cfg, req_tdata[31:0], req_tdata[63:32],
                                       req_tdata[71:64]);
            want.last  = req_tlast;
            pending_pixels.push_back(want);
         end
         pending_count <= pending_pixels.size();
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               ptcb_pkg::REG_MODE:       blend_cfg.mode       <= csr_pwdata[0];
               ptcb_pkg::REG_FORMAT:     blend_cfg.format     <= csr_pwdata[1:0];
               ptcb_pkg::REG_TINT_COLOR: blend_cfg.tint_color <= csr_pwdata[23:0];
               ptcb_pkg::REG_TINT_ALPHA: blend_cfg.tint_alpha <= csr_pwdata[7:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== bench/pixel_tint_compose_blend_tb.sv =====
`timescale 1ns / 100ps

module pixel_tint_compose_blend_tb;

   localparam int CYCLE_LIMIT = 300000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // fore_pixel[31:0], back_pixel[63:32], mask_alpha[71:64]
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;       // out_pixel[31:0]
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatch_count;
   int pending_count;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count = 0;

   pixel_tint_compose_blend dut (.*);

   pixel_blend_checker blend_check (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .mismatch_count, .pending_count
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_pixel(logic [31:0] fore, logic [31:0] back, logic [7:0] mask,
                             logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {mask, back, fore};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(logic mode, logic [1:0] fmt, logic [23:0] color,
                                logic [7:0] alpha);
      write_reg(ptcb_pkg::REG_MODE, {31'b0, mode});
      write_reg(ptcb_pkg::REG_FORMAT, {30'b0, fmt});
      write_reg(ptcb_pkg::REG_TINT_COLOR, {8'b0, color});
      write_reg(ptcb_pkg::REG_TINT_ALPHA, {24'b0, alpha});
      @(posedge clock);
   endtask

   initial begin
      logic       mode;
      logic [1:0] fmt;
      logic [23:0] color;
      logic [7:0] alpha;
      logic [7:0] mask;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 14;
      recv_idle_pct = 84;
      for (int d = 0; d < 5; d++) begin
         case (d)
            0: apply_setting(ptcb_pkg::MODE_TINT, ptcb_pkg::FMT_32, 24'hffffff, 8'hff);
            1: apply_setting(ptcb_pkg::MODE_COMPOSE, ptcb_pkg::FMT_32, 24'h000000, 8'h00);
            2: apply_setting(ptcb_pkg::MODE_COMPOSE, ptcb_pkg::FMT_565, 24'hffffff, 8'h80);
            3: apply_setting(ptcb_pkg::MODE_TINT, ptcb_pkg::FMT_555, 24'hffffff, 8'h80);
            default: apply_setting(ptcb_pkg::MODE_TINT, ptcb_pkg::FMT_24, 24'h000000, 8'h00);
         endcase
         send_pixel(32'hffffffff, 32'h00000000, 8'hff, 1'b0);
         send_pixel(32'h00000000, 32'hffffffff, 8'h00, 1'b1);
         send_pixel(32'hffffffff, 32'hffffffff, 8'hff, 1'b0);
         send_pixel(32'h00000000, 32'h00000000, 8'h80, 1'b1);
         send_pixel($urandom, $urandom, 8'($urandom_range(255)), 1'($urandom_range(1)));
         drain_pipeline();
      end

      for (int p = 0; p < 12; p++) begin
         case (p / 4)
            0: begin send_idle_pct = 14; recv_idle_pct = 84; end
            1: begin send_idle_pct = 84; recv_idle_pct = 14; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (p < 8) begin
            mode = p[0];
            fmt  = p[2:1];
         end else begin
            mode = 1'($urandom_range(1));
            fmt  = 2'($urandom_range(3));
         end
         case (p % 3)
            0: color = 24'hffffff;
            1: color = 24'h000000;
            default: color = 24'($urandom);
         endcase
         case (p % 4)
            0: alpha = 8'h00;
            1: alpha = 8'hff;
            default: alpha = 8'($urandom_range(255));
         endcase
         drain_pipeline();
         apply_setting(mode, fmt, color, alpha);
         repeat (70) begin
            case ($urandom_range(9))
               0: mask = 8'h00;
               1: mask = 8'hff;
               default: mask = 8'($urandom_range(255));
            endcase
            send_pixel($urandom, $urandom, mask, $urandom_range(7) == 0);
         end
      end

      drain_pipeline();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/ptcb_pkg.sv
sv/ptcb_prep.sv
sv/ptcb_mul.sv
sv/ptcb_pack.sv
sv/pixel_tint_compose_blend.sv
sv/ptcb_checker.sv
bench/pixel_blend_checker.sv
bench/pixel_tint_compose_blend_tb.sv
